// File: sv/median_filter_3x3_assert.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define MF3X3_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("median filter assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define MF3X3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("median filter assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define MF3X3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("median filter assertion failed");
`else
`define MF3X3_ASSERT(label, cond)
`define MF3X3_ASSERT_NOW(label, ante, cons)
`define MF3X3_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/mf3x3_pkg.sv
// Shared constants and types of the 3x3 median filter.
package mf3x3_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int CFG_W_W = 11;
  localparam int CFG_H_W = 13;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CFG_W_W-1:0] RESET_WIDTH  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] RESET_HEIGHT = CFG_H_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Load command from the window stage into the result buffer.
  typedef struct packed {
    logic load;
    logic pair;
  } rbuf_load_t;

endpackage

// File: sv/mf3x3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mf3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/mf3x3_median.sv
// Nine-input median selection network built from compare-exchange cells.
module mf3x3_median (
  input  logic [mf3x3_pkg::PIX_W-1:0] taps [9],
  output logic [mf3x3_pkg::PIX_W-1:0] med
);

  localparam int PW = mf3x3_pkg::PIX_W;

  // Returns {larger, smaller}.
  function automatic logic [2*PW-1:0] cas(input logic [PW-1:0] a, input logic [PW-1:0] b);
    cas = (a > b) ? {a, b} : {b, a};
  endfunction

  always_comb begin
    logic [PW-1:0] p [9];
    p = taps;
    {p[2], p[1]} = cas(p[1], p[2]);
    {p[5], p[4]} = cas(p[4], p[5]);
    {p[8], p[7]} = cas(p[7], p[8]);
    {p[1], p[0]} = cas(p[0], p[1]);
    {p[4], p[3]} = cas(p[3], p[4]);
    {p[7], p[6]} = cas(p[6], p[7]);
    {p[2], p[1]} = cas(p[1], p[2]);
    {p[5], p[4]} = cas(p[4], p[5]);
    {p[8], p[7]} = cas(p[7], p[8]);
    {p[3], p[0]} = cas(p[0], p[3]);
    {p[8], p[5]} = cas(p[5], p[8]);
    {p[7], p[4]} = cas(p[4], p[7]);
    {p[6], p[3]} = cas(p[3], p[6]);
    {p[4], p[1]} = cas(p[1], p[4]);
    {p[5], p[2]} = cas(p[2], p[5]);
    {p[7], p[4]} = cas(p[4], p[7]);
    {p[2], p[4]} = cas(p[4], p[2]);
    {p[4], p[6]} = cas(p[6], p[4]);
    {p[2], p[4]} = cas(p[4], p[2]);
    med = p[4];
  end

endmodule

// File: sv/mf3x3_rbuf.sv
// Two-entry result buffer that holds all results of one pixel.
module mf3x3_rbuf #(
  parameter int W = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mf3x3_pkg::rbuf_load_t ctl,
  input  logic [W-1:0]          r0,
  input  logic [W-1:0]          r1,
  output logic                  can_load,
  output logic                  valid,
  input  logic                  stall,
  output logic [W-1:0]          data
);

  logic [1:0]   count;
  logic [W-1:0] e0;
  logic [W-1:0] e1;
  logic         take;

  assign valid    = (count != 2'd0);
  assign take     = valid && !stall;
  assign can_load = (count == 2'd0) || ((count == 2'd1) && take);
  assign data     = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (ctl.load) begin
      count <= ctl.pair ? 2'd2 : 2'd1;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      e0 <= r0;
      e1 <= r1;
    end else if (take) begin
      e0 <= e1;
    end
  end

endmodule

// File: sv/median_filter_3x3.sv
// Top level of the streaming 3x3 median filter for 8-bit gray frames.
//
// Pixels enter in raster order (x fastest) on the pixel channel: a request
// is taken at a rising edge with pixel_valid high and pixel_stall low.
// Results leave on the result channel under the same rule with
// result_valid and result_stall. Each result carries out_x, out_y,
// out_value and run_last, which marks the last result caused by a pixel.
// A pixel at (x,y) with x>=2 and y>=2 first yields the median centred at
// (x-1,y-1); a pixel on the frame border then yields itself unchanged.
// Frame size comes from the APB registers image_width (0x0) and
// image_height (0x4); writing either restarts the frame at (0,0).
// A pixel passes the pixel register, then the result buffer. One pixel
// per cycle is sustained while each pixel yields at most one result and
// result_stall stays low; a pixel with two results holds the pixel
// channel back, as the single result port takes one result at a time.
// Line store reads come from two RAMs with registered read data, so they
// are ready together with the pixel register the window stage works on.
// Reset clears the position counters, window and result buffer and loads
// 640x480; line stores are not cleared, their reads are gated by row.
// When result_stall is high the result buffer holds its data and
// pixel_stall rises once the window stage cannot pass its pixel on.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = mf3x3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3x3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mf3x3_pkg::ADDR_W-1:0]        paddr,
  input  logic [mf3x3_pkg::DATA_W-1:0]        pwdata,
  output logic [mf3x3_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  // Pixel channel.
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [mf3x3_pkg::PIX_W-1:0]         pixel_in,
  // Result channel.
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_x,
  output logic [$clog2(MAX_HEIGHT)-1:0]       out_y,
  output logic [mf3x3_pkg::PIX_W-1:0]         out_value,
  output logic                                run_last
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XW1 = XW + 1;
  localparam int YW1 = YW + 1;
  localparam int PW  = mf3x3_pkg::PIX_W;
  localparam int RW  = XW + YW + PW + 1;

  // Configuration registers and effective frame size.
  logic [mf3x3_pkg::CFG_W_W-1:0] image_width;
  logic [mf3x3_pkg::CFG_H_W-1:0] image_height;
  logic                          cfg_we;
  mf3x3_pkg::reg_idx_t           cfg_idx;
  logic [XW:0]                   eff_w;
  logic [YW:0]                   eff_h;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = mf3x3_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3x3_pkg::RESET_WIDTH;
      image_height <= mf3x3_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_idx)
        mf3x3_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[mf3x3_pkg::CFG_W_W-1:0];
        mf3x3_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[mf3x3_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mf3x3_pkg::REG_IMAGE_WIDTH:  prdata = mf3x3_pkg::DATA_W'(image_width);
      mf3x3_pkg::REG_IMAGE_HEIGHT: prdata = mf3x3_pkg::DATA_W'(image_height);
      default:                     prdata = '0;
    endcase
  end

  // A zero size acts as one, an oversize value as the maximum.
  always_comb begin
    if (image_width == '0) begin
      eff_w = XW1'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = XW1'(MAX_WIDTH);
    end else begin
      eff_w = XW1'(image_width);
    end
    if (image_height == '0) begin
      eff_h = YW1'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = YW1'(MAX_HEIGHT);
    end else begin
      eff_h = YW1'(image_height);
    end
  end

  // Raster position of the next pixel.
  logic [XW-1:0] column_pos;
  logic [YW-1:0] row_pos;
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  logic [XW:0]   x_inc;
  logic [YW:0]   y_inc;
  logic          in_accept;

  assign in_accept = pixel_valid && !pixel_stall;
  assign cur_x = ({1'b0, column_pos} >= eff_w) ? '0 : column_pos;
  assign cur_y = ({1'b0, row_pos} >= eff_h) ? '0 : row_pos;
  assign x_inc = {1'b0, cur_x} + XW1'(1);
  assign y_inc = {1'b0, cur_y} + YW1'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (in_accept) begin
      if (x_inc >= eff_w) begin
        column_pos <= '0;
        row_pos    <= (y_inc >= eff_h) ? '0 : y_inc[YW-1:0];
      end else begin
        column_pos <= x_inc[XW-1:0];
      end
    end
  end

  // Pixel register: holds the pixel while its line store reads complete.
  logic          s1_valid;
  logic [PW-1:0] s1_pix;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  logic          s1_med;
  logic          s1_bord;
  logic          s1_has_mid;
  logic          s1_has_top;
  logic          s1_fire;
  logic          s1_none;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix     <= pixel_in;
      s1_x       <= cur_x;
      s1_y       <= cur_y;
      s1_med     <= (cur_x >= XW'(2)) && (cur_y >= YW'(2));
      s1_bord    <= (cur_x == '0) || (cur_y == '0) ||
                    ({1'b0, cur_x} == eff_w - XW1'(1)) ||
                    ({1'b0, cur_y} == eff_h - YW1'(1));
      s1_has_mid <= (cur_y >= YW'(1));
      s1_has_top <= (cur_y >= YW'(2));
    end
  end

  // Line stores: row y-1 and row y-2. Read at acceptance, written when the
  // pixel leaves the window stage.
  logic [PW-1:0] prev_rdata;
  logic [PW-1:0] older_rdata;

  mf3x3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_x),
    .wdata (s1_pix),
    .re    (in_accept),
    .raddr (cur_x),
    .rdata (prev_rdata)
  );

  mf3x3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_older (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_x),
    .wdata (prev_rdata),
    .re    (in_accept),
    .raddr (cur_x),
    .rdata (older_rdata)
  );

  // Window: two earlier columns plus the column formed by this pixel.
  logic [PW-1:0] win [6];
  logic [PW-1:0] top;
  logic [PW-1:0] mid;
  logic [PW-1:0] taps [9];
  logic [PW-1:0] med;

  assign top = s1_has_top ? older_rdata : '0;
  assign mid = s1_has_mid ? prev_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_pix;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      taps[i] = win[i];
    end
    taps[6] = top;
    taps[7] = mid;
    taps[8] = s1_pix;
  end

  mf3x3_median u_median (
    .taps (taps),
    .med  (med)
  );

  // Results of the pixel in the window stage.
  mf3x3_pkg::rbuf_load_t rb_ctl;
  logic [RW-1:0]         r0;
  logic [RW-1:0]         r1;
  logic [RW-1:0]         rb_data;
  logic                  rb_can_load;

  assign s1_none = !s1_med && !s1_bord;
  // A pixel with no result leaves without waiting for the buffer.
  assign s1_fire = s1_valid && (s1_none || rb_can_load);
  assign pixel_stall = s1_valid && !s1_fire;

  assign rb_ctl.load = s1_fire && !s1_none;
  assign rb_ctl.pair = s1_med && s1_bord;

  assign r1 = {s1_x, s1_y, s1_pix, 1'b1};
  assign r0 = s1_med ? {s1_x - XW'(1), s1_y - YW'(1), med, !s1_bord} : r1;

  mf3x3_rbuf #(
    .W (RW)
  ) u_rbuf (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rb_ctl),
    .r0       (r0),
    .r1       (r1),
    .can_load (rb_can_load),
    .valid    (result_valid),
    .stall    (result_stall),
    .data     (rb_data)
  );

  assign {out_x, out_y, out_value, run_last} = rb_data;

  // Assertions.
`include "median_filter_3x3_assert.svh"

  `MF3X3_ASSERT_NOW(a_idle_no_stall, !s1_valid, !pixel_stall)
  `MF3X3_ASSERT_NEXT(a_pair_follows, result_valid && !run_last, result_valid)
  `MF3X3_ASSERT_NEXT(a_cfg_restart, cfg_we, (column_pos == '0) && (row_pos == '0))
  `MF3X3_ASSERT_NOW(a_x_in_frame, s1_valid, ({1'b0, s1_x} < eff_w))

endmodule

// File: verif/median_filter_3x3_checker.sv
// Scoreboard for the 3x3 median filter: follows the register port and both channels.
module median_filter_3x3_checker #(
  parameter int MAX_WIDTH  = mf3x3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3x3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mf3x3_pkg::ADDR_W-1:0]        paddr,
  input  logic [mf3x3_pkg::DATA_W-1:0]        pwdata,
  input  logic [mf3x3_pkg::DATA_W-1:0]        prdata,
  input  logic                                pready,
  input  logic                                pixel_valid,
  input  logic                                pixel_stall,
  input  logic [mf3x3_pkg::PIX_W-1:0]         pixel_in,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic [$clog2(MAX_WIDTH)-1:0]        out_x,
  input  logic [$clog2(MAX_HEIGHT)-1:0]       out_y,
  input  logic [mf3x3_pkg::PIX_W-1:0]         out_value,
  input  logic                                run_last,
  output int                                  mismatch_count,
  output int                                  outstanding
);

  localparam int PIX_W   = mf3x3_pkg::PIX_W;
  localparam int CFG_W_W = mf3x3_pkg::CFG_W_W;
  localparam int CFG_H_W = mf3x3_pkg::CFG_H_W;
  localparam int ADDR_W  = mf3x3_pkg::ADDR_W;
  localparam int DATA_W  = mf3x3_pkg::DATA_W;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] WIDTH_ADDR  = ADDR_W'(4 * mf3x3_pkg::REG_IMAGE_WIDTH);
  localparam logic [ADDR_W-1:0] HEIGHT_ADDR = ADDR_W'(4 * mf3x3_pkg::REG_IMAGE_HEIGHT);

  typedef struct packed {
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [PIX_W-1:0] value;
    logic             last;
  } filtered_pix_t;

  logic [CFG_W_W-1:0] width_reg;
  logic [CFG_H_W-1:0] height_reg;
  logic [PIX_W-1:0]   row_above [MAX_WIDTH];
  logic [PIX_W-1:0]   row_two_above [MAX_WIDTH];
  logic [PIX_W-1:0]   win [6];
  int unsigned        col;
  int unsigned        row;
  filtered_pix_t      due_pixels [$];

  function automatic logic [PIX_W-1:0] median_of_nine(input logic [8:0][PIX_W-1:0] v);
    logic [PIX_W-1:0] s [9];
    logic [PIX_W-1:0] t;
    int j;
    for (int i = 0; i < 9; i++) s[i] = v[i];
    for (int i = 1; i < 9; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[4];
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic restart_frame();
    col = 0;
    row = 0;
    for (int i = 0; i < 6; i++) win[i] = '0;
  endtask

  // Works out the results caused by one pixel and moves the raster position on.
  task automatic filter_step(input logic [PIX_W-1:0] pix);
    int unsigned w, h, x, y;
    logic [PIX_W-1:0] top, mid;
    logic [8:0][PIX_W-1:0] nb;
    logic border;
    filtered_pix_t r;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    x = (col >= w) ? 0 : col;
    y = (row >= h) ? 0 : row;
    top = (y >= 2) ? row_two_above[x] : '0;
    mid = (y >= 1) ? row_above[x] : '0;
    border = (x == 0) || (y == 0) || (x == w - 1) || (y == h - 1);
    if (x >= 2 && y >= 2) begin
      for (int i = 0; i < 6; i++) nb[i] = win[i];
      nb[6] = top;
      nb[7] = mid;
      nb[8] = pix;
      r.x = XW'(x - 1);
      r.y = YW'(y - 1);
      r.value = median_of_nine(nb);
      r.last = !border;
      due_pixels.push_back(r);
    end
    if (border) begin
      r.x = XW'(x);
      r.y = YW'(y);
      r.value = pix;
      r.last = 1'b1;
      due_pixels.push_back(r);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = pix;
    row_two_above[x] = row_above[x];
    row_above[x] = pix;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col = x;
    row = y;
  endtask

  always @(posedge clk) begin
    filtered_pix_t got, exp;
    if (rst) begin
      width_reg = mf3x3_pkg::RESET_WIDTH;
      height_reg = mf3x3_pkg::RESET_HEIGHT;
      restart_frame();
      due_pixels.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pready && pwrite) begin
        if (paddr == WIDTH_ADDR) begin
          width_reg = pwdata[CFG_W_W-1:0];
          restart_frame();
        end else if (paddr == HEIGHT_ADDR) begin
          height_reg = pwdata[CFG_H_W-1:0];
          restart_frame();
        end
      end
      if (psel && penable && pready && !pwrite) begin
        if (paddr == WIDTH_ADDR && prdata !== DATA_W'(width_reg))
          note_failure($sformatf("image_width read: expected %0d, got %0h", width_reg, prdata));
        if (paddr == HEIGHT_ADDR && prdata !== DATA_W'(height_reg))
          note_failure($sformatf("image_height read: expected %0d, got %0h", height_reg, prdata));
      end
      // Results are taken before the new pixel: a pixel can never cause a result
      // at the edge at which it is accepted.
      if (result_valid && !result_stall) begin
        got = {out_x, out_y, out_value, run_last};
        if (due_pixels.size() == 0) begin
          note_failure($sformatf("unexpected result x=%0d y=%0d value=%0d last=%0b",
                                 out_x, out_y, out_value, run_last));
        end else begin
          exp = due_pixels.pop_front();
          if (got !== exp)
            note_failure({$sformatf("result mismatch: expected x=%0d y=%0d value=%0d last=%0b",
                                    exp.x, exp.y, exp.value, exp.last),
                          $sformatf(", got x=%0d y=%0d value=%0d last=%0b",
                                    got.x, got.y, got.value, got.last)});
        end
      end
      if (pixel_valid && !pixel_stall) filter_step(pixel_in);
    end
    outstanding <= due_pixels.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top of the 3x3 median filter: clock, reset, stimulus and verdict.
module tb;

  localparam int ADDR_W             = mf3x3_pkg::ADDR_W;
  localparam int DATA_W             = mf3x3_pkg::DATA_W;
  localparam int PIX_W              = mf3x3_pkg::PIX_W;
  localparam int CFG_W_W            = mf3x3_pkg::CFG_W_W;
  localparam int CFG_H_W            = mf3x3_pkg::CFG_H_W;
  localparam int DEFAULT_MAX_WIDTH  = mf3x3_pkg::DEFAULT_MAX_WIDTH;
  localparam int DEFAULT_MAX_HEIGHT = mf3x3_pkg::DEFAULT_MAX_HEIGHT;

  localparam int XW = $clog2(DEFAULT_MAX_WIDTH);
  localparam int YW = $clog2(DEFAULT_MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] WIDTH_ADDR  = ADDR_W'(4 * mf3x3_pkg::REG_IMAGE_WIDTH);
  localparam logic [ADDR_W-1:0] HEIGHT_ADDR = ADDR_W'(4 * mf3x3_pkg::REG_IMAGE_HEIGHT);

  // Which size registers a reprogramming touches; the values form a bit mask.
  localparam int WRITE_WIDTH  = 1;
  localparam int WRITE_HEIGHT = 2;
  localparam int WRITE_BOTH   = 3;

  // Pixel value patterns: uniform, a narrow band full of ties, and black/white only.
  localparam int PIX_UNIFORM = 0;
  localparam int PIX_TIES    = 1;
  localparam int PIX_EXTREME = 2;

  localparam int SETTLE_CYCLES = 8;     // comfortably above the pixel-to-result latency
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
  localparam int PHASE_ITEMS   = 270;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [PIX_W-1:0]     pixel_in = '0;

  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [XW-1:0]        out_x;
  logic [YW-1:0]        out_y;
  logic [PIX_W-1:0]     out_value;
  logic                 run_last;

  int mismatch_count;
  int outstanding;

  // Frame size as last programmed, used only to size the request bursts.
  int cur_w = 640;
  int cur_h = 480;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // The stimulus bumps hold_req to ask the receiver for one long hold-off.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  median_filter_3x3 dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pixel_valid, .pixel_stall, .pixel_in,
    .result_valid, .result_stall, .out_x, .out_y, .out_value, .run_last
  );

  median_filter_3x3_checker scoreboard (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pixel_valid, .pixel_stall, .pixel_in,
    .result_valid, .result_stall, .out_x, .out_y, .out_value, .run_last,
    .mismatch_count, .outstanding
  );

  always #6 clk = ~clk;

  // Receiver side. Outside a requested hold-off it stalls at random with the
  // probability of the current idling phase. A hold-off is counted here so
  // that the sender keeps offering requests while the block fills up.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: a correct run never goes this long without a single transfer
  // on one of the three ports, long hold-off included.
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // One register transfer: setup cycle, then access cycle until pready.
  // The bus is released before the task returns so that back-to-back calls
  // never assign psel twice in one time step.
  task automatic reg_access(input logic [ADDR_W-1:0] addr, input logic is_write,
                            input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drops valid and waits until every expected result has arrived, plus a
  // margin for pixels that cause no result but may still be in the pipeline.
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprograms the frame size with the block idle and reads the registers
  // back. The bits above each register's width carry random junk, which
  // the block must drop.
  task automatic program_size(input int w_val, input int h_val, input int which);
    logic [DATA_W-1:0] wmask, hmask;
    wmask = (DATA_W'(1) << CFG_W_W) - 1;
    hmask = (DATA_W'(1) << CFG_H_W) - 1;
    settle();
    if (which & WRITE_WIDTH) begin
      reg_access(WIDTH_ADDR, 1'b1, ($urandom() & ~wmask) | (DATA_W'(w_val) & wmask));
      cur_w = w_val;
    end
    if (which & WRITE_HEIGHT) begin
      reg_access(HEIGHT_ADDR, 1'b1, ($urandom() & ~hmask) | (DATA_W'(h_val) & hmask));
      cur_h = h_val;
    end
    reg_access(WIDTH_ADDR, 1'b0, '0);
    reg_access(HEIGHT_ADDR, 1'b0, '0);
  endtask

  // Offers one pixel, with random gaps before it, and returns in the time
  // step of the edge at which it was accepted. Valid stays high on return so
  // that consecutive pixels can go back to back.
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_in <= v;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [PIX_W-1:0] next_pixel(input int pattern);
    case (pattern)
      PIX_TIES:    return PIX_W'(8'h40 + $urandom_range(0, 2));
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Size of the frame as the block sees it, clamped to 1..maximum.
  function automatic int frame_pixels();
    int we, he;
    we = (cur_w == 0) ? 1 : ((cur_w > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : cur_w);
    he = (cur_h == 0) ? 1 : ((cur_h > DEFAULT_MAX_HEIGHT) ? DEFAULT_MAX_HEIGHT : cur_h);
    return we * he;
  endfunction

  // One random burst: a new frame size, then one or two frames, sometimes
  // with a partial frame after them that the next reprogramming cuts short.
  // Bursts are capped at 150 pixels, so huge frames are only entered.
  task automatic random_burst();
    int w_val, h_val, which, fp, n_pix, pattern;
    case ($urandom_range(0, 9))
      0:       w_val = 0;
      1:       w_val = $urandom_range(1, 2);
      2:       w_val = $urandom_range(DEFAULT_MAX_WIDTH + 1, 2047);
      9:       w_val = $urandom_range(13, 40);
      default: w_val = $urandom_range(3, 12);
    endcase
    case ($urandom_range(0, 9))
      0:       h_val = 0;
      1:       h_val = $urandom_range(1, 2);
      2:       h_val = $urandom_range(DEFAULT_MAX_HEIGHT + 1, 8191);
      default: h_val = $urandom_range(3, 9);
    endcase
    case ($urandom_range(0, 3))
      0:       which = WRITE_WIDTH;
      1:       which = WRITE_HEIGHT;
      default: which = WRITE_BOTH;
    endcase
    program_size(w_val, h_val, which);
    fp = frame_pixels();
    n_pix = fp * $urandom_range(1, 2);
    if ($urandom_range(0, 2) == 0) n_pix += $urandom_range(0, fp - 1);
    if (n_pix > 150) n_pix = $urandom_range(100, 150);
    pattern = $urandom_range(0, 3);
    repeat (n_pix) begin
      // Now and then the sender waits for the block to drain completely.
      if ($urandom_range(0, 99) == 0) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      send_pixel(next_pixel(pattern));
    end
  endtask

  initial begin
    logic [PIX_W-1:0] corner_vals [9];
    int phase_goal;
    corner_vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80, 8'h01, 8'h7F};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. First the reset size: a few first-row pixels, then a
    // read of both registers with nothing written yet.
    repeat (3) send_pixel(next_pixel(PIX_UNIFORM));
    settle();
    reg_access(WIDTH_ADDR, 1'b0, '0);
    reg_access(HEIGHT_ADDR, 1'b0, '0);

    // Smallest frame with an interior: one median from first-rows data,
    // every other pixel passed through as border.
    program_size(3, 3, WRITE_BOTH);
    for (int i = 0; i < 9; i++) send_pixel(corner_vals[i]);

    // Zero sizes act as one: every pixel is its own frame.
    program_size(0, 0, WRITE_BOTH);
    repeat (3) send_pixel(next_pixel(PIX_EXTREME));

    // Largest legal sizes, entered only.
    program_size(DEFAULT_MAX_WIDTH, DEFAULT_MAX_HEIGHT, WRITE_BOTH);
    repeat (3) send_pixel(next_pixel(PIX_UNIFORM));

    // Frame too small for any median.
    program_size(2, 2, WRITE_BOTH);
    repeat (4) send_pixel(next_pixel(PIX_UNIFORM));

    // Random part in three idling phases: sender idle 19% and receiver 67%,
    // then the reverse, then no idling at all.
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct <= 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct <= 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (ph == 2) begin
        // The receiver holds off for a long stretch while pixels keep
        // coming, so the block must fill up and stall its input.
        program_size(6, 6, WRITE_BOTH);
        hold_req <= hold_req + 1;
        repeat (90) send_pixel(next_pixel(PIX_UNIFORM));
      end
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) random_burst();
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
